### src/mix_and_centered_box_smoother_unit_macros.svh
// ---------------------------------------------------------------------------
// mix_and_centered_box_smoother_unit_macros
// assertion helpers shared by the smoother rtl, clocked on clk_i / rst_ni
// ---------------------------------------------------------------------------
`ifndef MIX_AND_CENTERED_BOX_SMOOTHER_UNIT_MACROS_SVH
`define MIX_AND_CENTERED_BOX_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication
`define MCBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mcbs_pkg.sv
// ---------------------------------------------------------------------------
// mcbs_pkg
// shared types and constants of the mixer and centred box smoother
// ---------------------------------------------------------------------------
package mcbs_pkg;

  localparam int HalfWindow = 8;
  localparam int Taps       = 2 * HalfWindow + 1;
  localparam int TapW       = $clog2(Taps + 1);
  localparam int MW         = $clog2(HalfWindow + 1);
  localparam int SampleW    = 16;
  localparam int TotalW     = 21;
  localparam int MagW       = TotalW - 1;
  localparam int WordW      = 32;
  localparam int FmtW       = 2;

  localparam logic [FmtW-1:0] FmtFloat = 2'd0;
  localparam logic [FmtW-1:0] FmtPcm16 = 2'd1;

  localparam logic RegLoopbackFmt = 1'b0;
  localparam logic RegMicFmt      = 1'b1;

  typedef enum logic [1:0] {
    CK_ZERO,
    CK_PCM,
    CK_SAT,
    CK_NORM
  } cvt_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CNV,
    ST_UPD,
    ST_PICK,
    ST_SUB,
    ST_DIV,
    ST_OUT,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic                     start;
    logic signed [TotalW-1:0] dividend;
    logic [TapW-1:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [SampleW-1:0] quotient;
  } div_rsp_t;

endpackage

### src/mcbs_cvt.sv
// ---------------------------------------------------------------------------
// mcbs_cvt
// two-stage sample converter: float32 times 32767 or pcm16 to int16
// ---------------------------------------------------------------------------
module mcbs_cvt (
  input  logic                             clk_i,
  input  logic [mcbs_pkg::WordW-1:0]       word_i,
  input  logic [mcbs_pkg::FmtW-1:0]        fmt_i,
  input  logic                             present_i,
  output logic signed [mcbs_pkg::SampleW-1:0] value_o
);
  import mcbs_pkg::*;

  localparam int ProdW = 39;

  cvt_kind_e              kind_d, kind_q;
  logic [ProdW-1:0]       prod_q;
  logic [7:0]             exp_q;
  logic                   sign_q;
  logic [SampleW-1:0]     pcm_q;

  always_comb begin
    kind_d = CK_ZERO;
    if (present_i) begin
      case (fmt_i)
        FmtFloat: begin
          if (word_i[30:23] == 8'd0) begin
            kind_d = CK_ZERO;
          end else if (word_i[30:23] == 8'hff) begin
            kind_d = (word_i[22:0] != 23'd0) ? CK_ZERO : CK_SAT;
          end else begin
            kind_d = CK_NORM;
          end
        end
        FmtPcm16: kind_d = CK_PCM;
        default:  kind_d = CK_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    prod_q <= {15'd0, 1'b1, word_i[22:0]} * ProdW'(32767);
    exp_q  <= word_i[30:23];
    sign_q <= word_i[31];
    pcm_q  <= word_i[SampleW-1:0];
  end

  // round the 38/39 bit product to 24 bits, nearest even
  logic                big;
  logic [23:0]         keep;
  logic                guard, sticky;
  logic [24:0]         rnd;
  logic signed [9:0]   sh;
  logic [4:0]          nsh;
  logic [24:0]         mag;

  always_comb begin
    big    = prod_q[38];
    keep   = big ? prod_q[38:15] : prod_q[37:14];
    guard  = big ? prod_q[14] : prod_q[13];
    sticky = big ? (|prod_q[13:0]) : (|prod_q[12:0]);
    rnd    = {1'b0, keep} + 25'(guard && (sticky || keep[0]));
    sh     = $signed({2'b00, exp_q}) + (big ? 10'sd15 : 10'sd14) - 10'sd150;
    nsh    = 5'(-sh);
    mag    = '0;
    if (sh < 0 && sh >= -10'sd24) mag = rnd >> nsh;
  end

  always_comb begin
    case (kind_q)
      CK_PCM:  value_o = $signed(pcm_q);
      CK_SAT:  value_o = sign_q ? -16'sd32768 : 16'sd32767;
      CK_NORM: begin
        if (sh >= 0) begin
          value_o = sign_q ? -16'sd32768 : 16'sd32767;
        end else if (sign_q) begin
          value_o = (mag >= 25'd32768) ? -16'sd32768 : -$signed(mag[SampleW-1:0]);
        end else begin
          value_o = (mag >= 25'd32767) ? 16'sd32767 : $signed(mag[SampleW-1:0]);
        end
      end
      default: value_o = '0;
    endcase
  end

endmodule

### src/mcbs_div.sv
// ---------------------------------------------------------------------------
// mcbs_div
// restoring serial divider, one quotient bit a cycle, truncates toward zero
// ---------------------------------------------------------------------------
`include "mix_and_centered_box_smoother_unit_macros.svh"

module mcbs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcbs_pkg::div_req_t  req_i,
  output mcbs_pkg::div_rsp_t  rsp_o
);
  import mcbs_pkg::*;

  localparam int CntW = $clog2(MagW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [MagW-1:0]   quo_q, quo_d;
  logic [TapW-1:0]   rem_q, rem_d;
  logic [TapW-1:0]   dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [TapW:0]     trial;
  logic [TotalW-1:0] absval;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    trial  = {rem_q, quo_q[MagW-1]};
    absval = req_i.dividend[TotalW-1] ? TotalW'(-req_i.dividend) : TotalW'(req_i.dividend);
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = absval[MagW-1:0];
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      neg_d  = req_i.dividend[TotalW-1];
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = TapW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[MagW-2:0], 1'b1};
      end else begin
        rem_d = trial[TapW-1:0];
        quo_d = {quo_q[MagW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(MagW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed(quo_q[SampleW-1:0]) : $signed(quo_q[SampleW-1:0]);

  `MCBS_ASSERT_IMP(a_start_idle, req_i.start, !busy_q, "divider started while busy")
  `MCBS_ASSERT_NXT(a_done_after_busy, done_d, !busy_q, "divider busy after done")
  `MCBS_ASSERT_IMP(a_div_nonzero, req_i.start, req_i.divisor != '0, "divide by zero")

endmodule

### src/mcbs_seq.sv
// ---------------------------------------------------------------------------
// mcbs_seq
// sample history memory, running total and the per-item emit sequencer
// ---------------------------------------------------------------------------
`include "mix_and_centered_box_smoother_unit_macros.svh"

module mcbs_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mcbs_pkg::FmtW-1:0]       lb_fmt_i,
  input  logic [mcbs_pkg::FmtW-1:0]       mic_fmt_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mcbs_pkg::WordW-1:0]      lb_word_i,
  input  logic                            lb_present_i,
  input  logic [mcbs_pkg::WordW-1:0]      mic_word_i,
  input  logic                            mic_present_i,
  input  logic                            eos_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mcbs_pkg::SampleW-1:0]    out_sample_o,
  output logic                            out_final_o
);
  import mcbs_pkg::*;

  seq_state_e state_q, state_d;

  logic [WordW-1:0]          lw_q, mw_q;
  logic                      lp_q, mp_q, eos_q;
  logic signed [SampleW-1:0] lb_val, mic_val, mixed_d, mixed_q;
  logic signed [SampleW:0]   mix_sum;
  logic [TapW-1:0]           wptr_q, wptr_d, seen_q, seen_d, lcur_q, lcur_d;
  logic signed [TotalW-1:0]  total_q, total_d, sum_q, sum_d;
  logic [MW-1:0]             m_q, m_d;
  logic                      ov_q, ov_d, olast_q, olast_d;
  logic [SampleW-1:0]        odata_q, odata_d;

  logic [SampleW-1:0]        mem [Taps];
  logic [SampleW-1:0]        rdata_q;
  logic                      mem_we;
  logic [TapW-1:0]           mem_waddr, mem_raddr, next_slot, target, seen_m1;
  logic                      emit_ok, last_m;
  div_req_t                  dreq;
  div_rsp_t                  drsp;

  function automatic logic [TapW-1:0] lag_addr(logic [TapW-1:0] ptr, logic [TapW-1:0] k);
    logic [TapW:0] t;
    t = {1'b0, ptr} + (TapW + 1)'(Taps) - {1'b0, k};
    if (t >= (TapW + 1)'(Taps)) t = t - (TapW + 1)'(Taps);
    return t[TapW-1:0];
  endfunction

  mcbs_cvt u_cvt_lb (
    .clk_i, .word_i(lw_q), .fmt_i(lb_fmt_i), .present_i(lp_q), .value_o(lb_val)
  );

  mcbs_cvt u_cvt_mic (
    .clk_i, .word_i(mw_q), .fmt_i(mic_fmt_i), .present_i(mp_q), .value_o(mic_val)
  );

  mcbs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    mix_sum   = {lb_val[SampleW-1], lb_val} + {mic_val[SampleW-1], mic_val};
    if (mix_sum > 17'sd32767)       mixed_d = 16'sd32767;
    else if (mix_sum < -17'sd32768) mixed_d = -16'sd32768;
    else                            mixed_d = mix_sum[SampleW-1:0];
    next_slot = (wptr_q == TapW'(Taps - 1)) ? '0 : wptr_q + 1'b1;
    seen_m1   = seen_q - 1'b1;
    target    = ((TapW'(m_q) + TapW'(HalfWindow)) < seen_m1) ?
                (TapW'(m_q) + TapW'(HalfWindow)) : seen_m1;
    emit_ok   = (TapW'(m_q) < seen_q) && ((m_q == MW'(HalfWindow)) || eos_q);
    last_m    = (m_q == '0) || !eos_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_CNV;
      ST_CNV:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_PICK;
      ST_PICK: begin
        if (emit_ok) state_d = (lcur_q > target) ? ST_SUB : ST_DIV;
        else if (last_m) state_d = ST_DONE;
      end
      ST_SUB:  state_d = ST_PICK;
      ST_DIV:  if (drsp.done) state_d = ST_OUT;
      ST_OUT: begin
        if (!ov_q || out_ready_i) state_d = last_m ? ST_DONE : ST_PICK;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    wptr_d     = wptr_q;
    seen_d     = seen_q;
    total_d    = total_q;
    sum_d      = sum_q;
    lcur_d     = lcur_q;
    m_d        = m_q;
    ov_d       = ov_q && !out_ready_i;
    odata_d    = odata_q;
    olast_d    = olast_q;
    mem_we     = 1'b0;
    mem_waddr  = next_slot;
    mem_raddr  = next_slot;
    dreq.start    = 1'b0;
    dreq.dividend = sum_q;
    dreq.divisor  = lcur_q + 1'b1;
    case (state_q)
      ST_UPD: begin
        total_d = total_q + TotalW'(mixed_q)
                - ((seen_q == TapW'(Taps)) ? TotalW'($signed(rdata_q)) : '0);
        seen_d  = (seen_q == TapW'(Taps)) ? seen_q : seen_q + 1'b1;
        mem_we  = 1'b1;
        wptr_d  = next_slot;
        sum_d   = total_d;
        lcur_d  = seen_d - 1'b1;
        m_d     = MW'(HalfWindow);
      end
      ST_PICK: begin
        mem_raddr = lag_addr(wptr_q, lcur_q);
        if (emit_ok) begin
          dreq.start = !(lcur_q > target);
        end else if (!last_m) begin
          m_d = m_q - 1'b1;
        end
      end
      ST_SUB: begin
        sum_d  = sum_q - TotalW'($signed(rdata_q));
        lcur_d = lcur_q - 1'b1;
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          odata_d = drsp.quotient;
          olast_d = eos_q && (m_q == '0);
          if (!last_m) m_d = m_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (eos_q) begin
          seen_d  = '0;
          total_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mixed_q;
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      lw_q  <= lb_word_i;
      mw_q  <= mic_word_i;
      lp_q  <= lb_present_i;
      mp_q  <= mic_present_i;
      eos_q <= eos_i;
    end
    if (state_q == ST_CNV) mixed_q <= mixed_d;
    sum_q   <= sum_d;
    lcur_q  <= lcur_d;
    m_q     <= m_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wptr_q  <= '0;
      seen_q  <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      seen_q  <= seen_d;
      total_q <= total_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_sample_o = odata_q;
  assign out_final_o  = olast_q;

  `MCBS_ASSERT_IMP(a_seen_bound, 1'b1, seen_q <= TapW'(Taps), "sample count past window")
  `MCBS_ASSERT_NXT(a_eos_clears, (state_q == ST_DONE) && eos_q, seen_q == '0,
                   "history not cleared after end of stream")
  `MCBS_ASSERT_IMP(a_ptr_range, 1'b1, wptr_q < TapW'(Taps), "write pointer out of range")

endmodule

### src/mix_and_centered_box_smoother_unit.sv
// ---------------------------------------------------------------------------
// mix_and_centered_box_smoother_unit
// two-source sample mixer followed by a centred 17-tap box average
// ---------------------------------------------------------------------------
// input stream: tdata carries the loopback and microphone words, tuser their
// present flags, tlast marks the final sample of a recording. each input
// transfer produces the smoothed sample lagging 8 samples behind it (once 9
// samples are in), and a tlast transfer flushes up to 9 results, the last
// one with tlast set on the output stream.
// each item passes in turn through the accept state, two states that convert
// and mix, a read-modify-write of the history memory, a pick state, the
// serial divide by the neighbour count, an output state and a closing state;
// no new input is taken until the item is done. each further flushed result
// repeats the pick, divide and output states, with a subtract step for each
// sample leaving the window and one more pick for each lag skipped in a
// short stream. formats must be written over the apb port while the unit
// is idle; the unit itself does not enforce this.
// reset clears formats, the sample count and the running total; the history
// memory needs no clearing since only written entries are read.
// a stalled output holds its result in the output register; the unit keeps
// working up to the next result and then waits for the register to empty.
// ---------------------------------------------------------------------------
module mix_and_centered_box_smoother_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // loopback_word, mic_word
  input  logic [1:0]  s_axis_tuser,  // loopback_present, mic_present
  input  logic        s_axis_tlast,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // smoothed_sample
  output logic        m_axis_tlast
);
  import mcbs_pkg::*;

  logic [FmtW-1:0] lb_fmt_q, lb_fmt_d, mic_fmt_q, mic_fmt_d;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    lb_fmt_d  = lb_fmt_q;
    mic_fmt_d = mic_fmt_q;
    if (cfg_wr) begin
      case (paddr[2])
        RegLoopbackFmt: lb_fmt_d  = pwdata[FmtW-1:0];
        RegMicFmt:      mic_fmt_d = pwdata[FmtW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_fmt_q  <= '0;
      mic_fmt_q <= '0;
    end else begin
      lb_fmt_q  <= lb_fmt_d;
      mic_fmt_q <= mic_fmt_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegLoopbackFmt: prdata = {30'd0, lb_fmt_q};
      RegMicFmt:      prdata = {30'd0, mic_fmt_q};
      default:        prdata = '0;
    endcase
  end

  mcbs_seq u_seq (
    .clk_i,
    .rst_ni,
    .lb_fmt_i      (lb_fmt_q),
    .mic_fmt_i     (mic_fmt_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .lb_word_i     (s_axis_tdata[31:0]),
    .lb_present_i  (s_axis_tuser[0]),
    .mic_word_i    (s_axis_tdata[63:32]),
    .mic_present_i (s_axis_tuser[1]),
    .eos_i         (s_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_sample_o  (m_axis_tdata),
    .out_final_o   (m_axis_tlast)
  );

endmodule

### tb/mix_and_centered_box_smoother_unit_test.sv
// ---------------------------------------------------------------------------
// mix_and_centered_box_smoother_unit_test
// self-checking bench for the two-source mixer and centred box smoother
// ---------------------------------------------------------------------------
// drives sample pairs with random present flags and stream ends, and checks
// every output transfer against a local model of the mixer and smoother.
// the formats are rewritten between phases while the unit is idle. both
// streams idle at random. the receiver makes one long hold-off so that the
// unit fills up and stalls its input.
// ---------------------------------------------------------------------------
module mix_and_centered_box_smoother_unit_test;
  import mcbs_pkg::*;

  localparam int DrainCycles = 400;
  localparam int WatchLimit  = 6000;
  localparam int NumRandom   = 350;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  int  errors;
  int  results_seen;
  int  idle_cycles;

  mix_and_centered_box_smoother_unit uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } smoothed_t;

  class mix_smoother_sb;
    logic [1:0] lb_fmt;
    logic [1:0] mic_fmt;
    int         history[Taps];
    int         total;
    int         seen;
    smoothed_t  pending[$];

    function new();
      lb_fmt = '0;
      mic_fmt = '0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (history[k]) history[k] = 0;
      total = 0;
      seen = 0;
    endfunction

    // exact double product, then rounded to single the way the hardware sees it
    function int float_to_pcm(logic [31:0] w);
      int   ex;
      int   e;
      real  mag;
      real  p;
      real  ulp;
      real  x;
      real  r;
      ex = int'(w[30:23]);
      if (ex == 255) begin
        if (w[22:0] != 0) return 0;
        return w[31] ? -32768 : 32767;
      end
      if (ex == 0) mag = real'(w[22:0]) * (2.0 ** -149);
      else mag = (1.0 + real'(w[22:0]) / 8388608.0) * (2.0 ** (ex - 127));
      p = mag * 32767.0;
      // positive values clip at 32767, negative ones only from -32768 down
      if (!w[31] && p >= 32767.0) return 32767;
      if (w[31] && p >= 32768.0) return -32768;
      if (p < (2.0 ** -10)) return 0;
      e = 15;
      while ((2.0 ** e) > p) e--;
      ulp = 2.0 ** (e - 23);
      x = p / ulp;
      r = $floor(x);
      if ((x - r) > 0.5 || ((x - r) == 0.5 && ($rtoi(r) % 2) == 1)) r = r + 1.0;
      p = r * ulp;
      if (!w[31] && p >= 32767.0) return 32767;
      if (w[31] && p >= 32768.0) return -32768;
      return w[31] ? -$rtoi(p) : $rtoi(p);
    endfunction

    function int word_to_pcm(logic [31:0] w, logic [1:0] fmt);
      if (fmt == FmtFloat) return float_to_pcm(w);
      if (fmt == FmtPcm16) return int'($signed(w[15:0]));
      return 0;
    endfunction

    function void note_input(logic [63:0] data, logic [1:0] present, logic eos);
      int        a;
      int        b;
      int        mixed;
      int        sum;
      int        cnt;
      int        last_k;
      smoothed_t res;
      a = present[0] ? word_to_pcm(data[31:0], lb_fmt) : 0;
      b = present[1] ? word_to_pcm(data[63:32], mic_fmt) : 0;
      mixed = a + b;
      if (mixed > 32767) mixed = 32767;
      if (mixed < -32768) mixed = -32768;
      total -= history[Taps-1];
      for (int k = Taps - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = mixed;
      total += mixed;
      if (seen < Taps) seen++;
      // lag m of the emitted sample behind the newest one
      for (int m = HalfWindow; m >= 0; m--) begin
        if (m >= seen) continue;
        if (m < HalfWindow && !eos) continue;
        last_k = m + HalfWindow;
        if (last_k > seen - 1) last_k = seen - 1;
        if (m == HalfWindow) begin
          sum = total;
          cnt = seen;
        end else begin
          sum = 0;
          for (int k = 0; k <= last_k; k++) sum += history[k];
          cnt = last_k + 1;
        end
        res.sample = 16'(sum / cnt);
        res.last = eos && (m == 0);
        pending = {pending, res};
      end
      if (eos) clear_stream();
    endfunction

    task check_result(logic [15:0] sample, logic last);
      smoothed_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h last %b", sample, last));
        return;
      end
      want = pending.pop_front();
      if (sample !== want.sample)
        report_mismatch($sformatf("sample %h, wanted %h", sample, want.sample));
      if (last !== want.last)
        report_mismatch($sformatf("tlast %b, wanted %b", last, want.last));
    endtask
  endclass

  mix_smoother_sb sb = new();

  // monitor of both streams, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast);
        results_seen++;
        idle_cycles = 0;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no transfer for %0d cycles", WatchLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int  gap;
    bit  held;
    held = 0;
    m_axis_tready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (!held && results_seen > 120) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_formats(input logic [31:0] lb, input logic [31:0] mic);
    apb_write({RegLoopbackFmt, 2'b00}, lb);
    apb_write({RegMicFmt, 2'b00}, mic);
    sb.lb_fmt = lb[1:0];
    sb.mic_fmt = mic[1:0];
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [31:0] lb, input logic [31:0] mic,
                             input logic [1:0] present, input logic eos, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {mic, lb};
    s_axis_tuser <= present;
    s_axis_tlast <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom();
      1: w = {1'($urandom()), 8'($urandom_range(100, 127)), 23'($urandom())};
      2: w = {1'($urandom()), 8'($urandom_range(110, 128)), 23'($urandom())};
      3: begin
        case ($urandom_range(0, 5))
          0: w = 32'h7fc0_0000;
          1: w = 32'h7f80_0000;
          2: w = 32'hff80_0000;
          3: w = 32'h3f80_0000;
          4: w = 32'hbf80_0000;
          default: w = 32'h8000_0000;
        endcase
      end
      default: w = {1'($urandom()), 8'($urandom_range(118, 126)), 23'($urandom())};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_word(logic [1:0] fmt);
    if (fmt == FmtFloat) return rand_float();
    return $urandom();
  endfunction

  initial begin
    int          stream_len;
    int          count;
    logic [31:0] lb;
    logic [31:0] mic;
    errors = 0;
    results_seen = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // float extremes at reset formats: nan, infinities, full scale, zeros
    send_sample(32'h7fc0_0001, 32'h7f80_0000, 2'b11, 1'b0, 0);
    send_sample(32'hff80_0000, 32'h3f80_0000, 2'b11, 1'b0, 0);
    send_sample(32'h7f7f_ffff, 32'h7f7f_ffff, 2'b11, 1'b0, 0);
    send_sample(32'hff7f_ffff, 32'hbf80_0000, 2'b11, 1'b0, 0);
    send_sample(32'h8000_0000, 32'h0000_0001, 2'b11, 1'b0, 0);
    send_sample(32'h3f00_0000, 32'hbf00_0000, 2'b01, 1'b0, 0);
    send_sample(32'h3e80_0000, 32'hffff_ffff, 2'b10, 1'b0, 0);
    send_sample(32'h3f7f_ffff, 32'hbf7f_ffff, 2'b00, 1'b0, 0);
    // two more samples, the second ending the first stream with tlast
    send_sample(32'h3f80_0000, 32'h3f80_0000, 2'b11, 1'b0, 0);
    send_sample(32'hbf80_0000, 32'hbf80_0000, 2'b11, 1'b1, 0);
    // single-sample stream
    send_sample(32'h3f40_0000, 32'h0, 2'b01, 1'b1, 0);
    wait_drained();

    // pcm extremes, then unsupported codes with ignored upper bits
    set_formats(32'd1, 32'hffff_fffd);
    send_sample(32'hffff_7fff, 32'h0000_7fff, 2'b11, 1'b0, 0);
    send_sample(32'h0000_8000, 32'h0000_8000, 2'b11, 1'b0, 0);
    send_sample(32'h1234_8000, 32'h0000_0000, 2'b01, 1'b0, 0);
    send_sample(32'h0000_ffff, 32'hffff_ffff, 2'b11, 1'b1, 0);
    wait_drained();
    set_formats(32'hffff_fffe, 32'd3);
    send_sample(32'hffff_ffff, 32'h3f80_0000, 2'b11, 1'b0, 0);
    send_sample(32'h3f80_0000, 32'h0000_7fff, 2'b11, 1'b1, 0);
    wait_drained();

    // random phases over the format settings
    count = 0;
    while (count < NumRandom) begin
      set_formats($urandom_range(0, 3) | ($urandom() & 32'hffff_fffc) ,
                  $urandom_range(0, 3) | ($urandom() & 32'hffff_fffc));
      if (count == 0) set_formats(32'd1, 32'd1);
      if (count > NumRandom / 2 && $urandom_range(0, 2) == 0) set_formats(32'd0, 32'd0);
      for (int s = 0; s < 2 && count < NumRandom; s++) begin
        stream_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                 : $urandom_range(18, 60);
        for (int i = 0; i < stream_len && count < NumRandom; i++) begin
          lb = rand_word(sb.lb_fmt);
          mic = rand_word(sb.mic_fmt);
          send_sample(lb, mic, 2'($urandom()) | (($urandom_range(0, 3) != 0) ? 2'b11 : 2'b00),
                      (i == stream_len - 1) || (count == NumRandom - 1),
                      (results_seen > 110 && results_seen < 160));
          count++;
        end
      end
      wait_drained();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
